// ===== design/frpc_pkg.sv =====
// ----------------------------------------------------------------------------
// frpc_pkg: shared types and constants of the faw and refresh pair checker
// command codes, credit slot sizing, bank decode and result structs
// ----------------------------------------------------------------------------
`default_nettype none

package frpc_pkg;

   localparam int BANKS_PER_GROUP = 4;
   localparam int CREDIT_LIMIT    = 4;
   localparam int ROUND_BANKS     = 16;

   // live credit counts hold 0..CREDIT_LIMIT, sums add a cost of up to two
   localparam int CNT_W = $clog2(CREDIT_LIMIT + 1);
   localparam int SUM_W = CNT_W + 2;

   localparam logic OP_CHECK  = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   localparam logic [1:0] KIND_OTHER   = 2'd0;
   localparam logic [1:0] KIND_ACT2    = 2'd1;
   localparam logic [1:0] KIND_REFRESH = 2'd2;

   localparam logic [ROUND_BANKS-1:0] ROUND_FULL = '1;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [SUM_W-1:0] sum_type;

   typedef struct packed {
      cnt_type live_before;
      cnt_type live_after;
      logic    overflow;
   } credit_res_type;

   typedef struct packed {
      logic ok;
      logic repeat_err;
      logic done;
   } refresh_res_type;

   function automatic sum_type credit_cost(input logic [1:0] kind);
      sum_type cost;
      case (kind)
         KIND_ACT2:    cost = SUM_W'(1);
         KIND_REFRESH: cost = SUM_W'(2);
         default:      cost = '0;
      endcase
      return cost;
   endfunction

   function automatic logic [ROUND_BANKS-1:0] bank_bit(input logic [1:0] group,
                                                       input logic [1:0] bank);
      logic [3:0] idx;
      idx = {group, bank};
      return ROUND_BANKS'(1) << idx;
   endfunction

   // live count shown on the result, clamped to three bits
   function automatic logic [2:0] sat_live(input cnt_type live);
      logic [CNT_W+2:0] wide;
      wide = (CNT_W + 3)'(live);
      return (wide > (CNT_W + 3)'(7)) ? 3'd7 : wide[2:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/frpc_csr.sv =====
// ----------------------------------------------------------------------------
// frpc_csr: configuration registers
// apb-style write and read of window length and the two refresh gaps
// ----------------------------------------------------------------------------
`default_nettype none

module frpc_csr
   import frpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [15:0]      faw_window,
   output logic [15:0]      refresh_gap_short,
   output logic [15:0]      refresh_gap_long
);

   localparam logic [1:0] REG_FAW_WINDOW = 2'd0;
   localparam logic [1:0] REG_GAP_SHORT  = 2'd1;
   localparam logic [1:0] REG_GAP_LONG   = 2'd2;

   logic [15:0] faw_ff, faw_in;
   logic [15:0] gap_short_ff, gap_short_in;
   logic [15:0] gap_long_ff, gap_long_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      faw_in       = faw_ff;
      gap_short_in = gap_short_ff;
      gap_long_in  = gap_long_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_FAW_WINDOW: faw_in       = csr_pwdata[15:0];
            REG_GAP_SHORT:  gap_short_in = csr_pwdata[15:0];
            REG_GAP_LONG:   gap_long_in  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FAW_WINDOW: csr_prdata = {16'd0, faw_ff};
         REG_GAP_SHORT:  csr_prdata = {16'd0, gap_short_ff};
         REG_GAP_LONG:   csr_prdata = {16'd0, gap_long_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         faw_ff       <= 16'd32;
         gap_short_ff <= 16'd8;
         gap_long_ff  <= 16'd16;
      end else begin
         faw_ff       <= faw_in;
         gap_short_ff <= gap_short_in;
         gap_long_ff  <= gap_long_in;
      end
   end

   assign faw_window        = faw_ff;
   assign refresh_gap_short = gap_short_ff;
   assign refresh_gap_long  = gap_long_ff;

endmodule

`default_nettype wire

// ===== design/frpc_credit_tracker.sv =====
// ----------------------------------------------------------------------------
// frpc_credit_tracker: four-activate window credit slots
// counts live credits, expires old ones and stores new ones on record
// ----------------------------------------------------------------------------
`default_nettype none

module frpc_credit_tracker
   import frpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        record,
   input  wire sum_type     cost,
   input  wire logic [31:0] now,
   input  wire logic [15:0] faw_window,
   output credit_res_type   res
);

   logic [CREDIT_LIMIT-1:0] valid_ff, valid_in;
   logic [31:0]             stamp_ff [CREDIT_LIMIT];
   logic [CREDIT_LIMIT-1:0] live;
   logic [CREDIT_LIMIT-1:0] take;
   cnt_type                 live_cnt;
   cnt_type                 take_cnt;
   sum_type                 prefix;

   always_comb begin
      live     = '0;
      take     = '0;
      live_cnt = '0;
      take_cnt = '0;
      prefix   = '0;
      for (int i = 0; i < CREDIT_LIMIT; i++) begin
         live[i] = valid_ff[i] &&
                   ({1'b0, stamp_ff[i]} + {17'd0, faw_window} > {1'b0, now});
      end
      // fill free slots lowest first, up to the item's cost
      for (int i = 0; i < CREDIT_LIMIT; i++) begin
         if (live[i]) begin
            live_cnt = live_cnt + CNT_W'(1);
         end else begin
            take[i] = prefix < cost;
            prefix  = prefix + SUM_W'(1);
         end
         if (take[i]) begin
            take_cnt = take_cnt + CNT_W'(1);
         end
      end
   end

   assign valid_in = live | take;

   always_comb begin
      res.live_before = live_cnt;
      res.overflow    = record && (SUM_W'(take_cnt) < cost);
      // a fresh stamp is live only when the window is not empty
      res.live_after  = (record && faw_window != 16'd0) ? live_cnt + take_cnt :
                        live_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance && record) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CREDIT_LIMIT; i++) begin
         if (advance && record && take[i]) begin
            stamp_ff[i] <= now;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/frpc_refresh_tracker.sv =====
// ----------------------------------------------------------------------------
// frpc_refresh_tracker: dual-bank refresh round coverage
// holds the coverage mask and the earliest next refresh cycle
// ----------------------------------------------------------------------------
`default_nettype none

module frpc_refresh_tracker
   import frpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   issue,
   input  wire logic                   second,
   input  wire logic [ROUND_BANKS-1:0] pair,
   input  wire logic [31:0]            now,
   input  wire logic [15:0]            refresh_gap_short,
   input  wire logic [15:0]            refresh_gap_long,
   output refresh_res_type             res
);

   logic [ROUND_BANKS-1:0] mask_ff, mask_in;
   logic [31:0]            next_ff, next_in;
   logic [ROUND_BANKS-1:0] merged;
   logic                   hit;
   logic                   full;
   logic [32:0]            next_sum;

   assign merged   = mask_ff | pair;
   assign hit      = (mask_ff & pair) != '0;
   assign full     = merged == ROUND_FULL;
   assign next_sum = {1'b0, now} + {17'd0, full ? refresh_gap_long : refresh_gap_short};

   always_comb begin
      res.ok         = second && (now >= next_ff) && !hit;
      res.repeat_err = issue && second && hit;
      res.done       = issue && second && !hit && full;
      mask_in        = mask_ff;
      next_in        = next_ff;
      if (issue && second && !hit) begin
         mask_in = full ? '0 : merged;
         next_in = next_sum[32] ? 32'hFFFF_FFFF : next_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         next_ff <= 32'd0;
      end else if (advance) begin
         mask_ff <= mask_in;
         next_ff <= next_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/faw_and_refresh_pair_checker_core.sv =====
// ----------------------------------------------------------------------------
// faw_and_refresh_pair_checker_core: four-activate window and refresh pair checker
// checks or records act2 and dual-bank refresh commands against credit and
// refresh round rules, one result item per request item
// ----------------------------------------------------------------------------
//
//  channel   direction  carries
//  req_*     in         op and command kind (tuser), cycle and bank pair (tdata)
//  rsp_*     out        allowed, repeat, round done, overflow, live credits
//  csr_*     in/out     apb-style access to window length and refresh gaps
//
// an item goes from acceptance through the input register, then the result
// register, to the output; one item enters every cycle while the result is not stalled
// the credit slots and refresh state update at the same edge the result
// register loads, so the next item already sees them
// a stalled result holds the input register; req_tready then follows rsp_tready
// synchronous active-high reset empties both registers, clears credit valid
// bits, coverage mask and next refresh cycle, and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module faw_and_refresh_pair_checker_core
   import frpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] op, [2:1] command_kind
   input  wire logic [2:0]  req_tuser,
   // [31:0] cycle, [33:32] first_bank_group, [35:34] first_bank,
   // [36] second_present, [38:37] second_bank_group, [40:39] second_bank
   input  wire logic [47:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] allowed, [1] repeat_error, [2] round_done, [3] credit_overflow,
   // [6:4] live credit count
   output logic [7:0]       rsp_tdata,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration
   logic [15:0] faw_window;
   logic [15:0] refresh_gap_short;
   logic [15:0] refresh_gap_long;

   // input register
   logic        in_valid_ff;
   logic        op_ff;
   logic [1:0]  kind_ff;
   logic [31:0] cycle_ff;
   logic [1:0]  first_group_ff, first_bank_ff;
   logic        second_ff;
   logic [1:0]  second_group_ff, second_bank_ff;

   // result register
   logic        out_valid_ff;
   logic [7:0]  out_data_ff, out_data_in;

   logic            advance;
   logic            is_record;
   logic            is_refresh;
   sum_type         cost;
   logic [ROUND_BANKS-1:0] pair;
   credit_res_type  credit_res;
   refresh_res_type refresh_res;
   logic            credit_ok;
   logic            allowed;
   cnt_type         live_shown;

   // item moves from input to result register when the result slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff           <= req_tuser[0];
         kind_ff         <= req_tuser[2:1];
         cycle_ff        <= req_tdata[31:0];
         first_group_ff  <= req_tdata[33:32];
         first_bank_ff   <= req_tdata[35:34];
         second_ff       <= req_tdata[36];
         second_group_ff <= req_tdata[38:37];
         second_bank_ff  <= req_tdata[40:39];
      end
   end

   frpc_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .faw_window        (faw_window),
      .refresh_gap_short (refresh_gap_short),
      .refresh_gap_long  (refresh_gap_long)
   );

   assign is_record  = op_ff == OP_RECORD;
   assign is_refresh = kind_ff == KIND_REFRESH;
   assign cost       = credit_cost(kind_ff);
   assign pair       = bank_bit(first_group_ff, first_bank_ff) |
                       bank_bit(second_group_ff, second_bank_ff);

   frpc_credit_tracker u_credit (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .record     (is_record),
      .cost       (cost),
      .now        (cycle_ff),
      .faw_window (faw_window),
      .res        (credit_res)
   );

   frpc_refresh_tracker u_refresh (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .issue             (is_record && is_refresh),
      .second            (second_ff),
      .pair              (pair),
      .now               (cycle_ff),
      .refresh_gap_short (refresh_gap_short),
      .refresh_gap_long  (refresh_gap_long),
      .res               (refresh_res)
   );

   // rules judged on the state before this item, for both ops
   assign credit_ok  = (cost == '0) ||
                       (SUM_W'(credit_res.live_before) + cost <= SUM_W'(CREDIT_LIMIT));
   assign allowed    = credit_ok && (!is_refresh || refresh_res.ok);
   assign live_shown = is_record ? credit_res.live_after : credit_res.live_before;

   always_comb begin
      out_data_in = {1'b0, sat_live(live_shown), credit_res.overflow,
                     refresh_res.done, refresh_res.repeat_err, allowed};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   // an allowed record always finds enough free slots after expiry
   a_allowed_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (advance && is_record && allowed) |-> !credit_res.overflow)
      else $error("allowed record overflowed credit slots");

   // a bank pair cannot both repeat and close the round
   a_repeat_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("repeat and round done on one result");

   // shown live credits never exceed the slot count
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:4] <= 3'(CREDIT_LIMIT)))
      else $error("live credits above limit");

   // a check item leaves the repeat, round done and overflow flags clear
   a_check_clean: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_record) |=> (rsp_tdata[3:1] == 3'd0))
      else $error("check item raised record flags");

   // every moved item shows up as a result
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced item missing from result register");
`endif

endmodule

`default_nettype wire

// ===== tb/frpc_result_checker.sv =====
// ----------------------------------------------------------------------------
// frpc_result_checker: predicts and checks faw and refresh pair verdicts
// follows register writes and accepted request items, keeps its own credit
// slots, coverage mask and refresh deadline, and compares every result item
// field by field against the oldest predicted verdict
// ----------------------------------------------------------------------------
`default_nettype none

module frpc_result_checker
   import frpc_pkg::*;
#(
   parameter logic [3:0] ADDR_FAW_WINDOW = 4'h0,
   parameter logic [3:0] ADDR_GAP_SHORT  = 4'h4,
   parameter logic [3:0] ADDR_GAP_LONG   = 4'h8
)(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // [0] op, [2:1] command_kind
   input  wire logic [2:0]  req_tuser,
   // [31:0] cycle, [33:32] first_bank_group, [35:34] first_bank,
   // [36] second_present, [38:37] second_bank_group, [40:39] second_bank
   input  wire logic [47:0] req_tdata,

   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] allowed, [1] repeat_error, [2] round_done, [3] credit_overflow,
   // [6:4] live credit count
   input  wire logic [7:0]  rsp_tdata,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,

   output int               mismatch_count,
   output int               open_count
);

   typedef struct packed {
      logic       allowed;
      logic       repeat_err;
      logic       round_done;
      logic       overflow;
      logic [2:0] live;
   } verdict_type;

   logic [15:0]             faw_window;
   logic [15:0]             gap_short;
   logic [15:0]             gap_long;
   logic [31:0]             stamp [CREDIT_LIMIT];
   logic [CREDIT_LIMIT-1:0] stamp_valid;
   logic [15:0]             coverage;
   logic [31:0]             refresh_ready_at;

   verdict_type             pending_verdicts [$];
   verdict_type             want;
   verdict_type             got;
   int                      mismatches;

   function automatic logic is_live(input int slot, input logic [31:0] now);
      return stamp_valid[slot] &&
             (({1'b0, stamp[slot]} + 33'(faw_window)) > {1'b0, now});
   endfunction

   function automatic int live_at(input logic [31:0] now);
      int n;
      int i;
      n = 0;
      for (i = 0; i < CREDIT_LIMIT; i++)
         if (is_live(i, now)) n++;
      return n;
   endfunction

   // verdict of one command, updating credit and refresh state on a record
   task automatic judge_command(input logic op, input logic [1:0] kind,
                                input logic [31:0] now, input logic [3:0] first_idx,
                                input logic has_second, input logic [3:0] second_idx,
                                output verdict_type v);
      logic [15:0] pair;
      logic [32:0] next_at;
      logic        stored;
      int          cost;
      int          live;
      int          i;
      int          k;
      v = '0;
      v.allowed = 1'b1;
      pair = (16'd1 << first_idx) | (16'd1 << second_idx);
      case (kind)
         KIND_ACT2:    cost = 1;
         KIND_REFRESH: cost = 2;
         default:      cost = 0;
      endcase
      live = live_at(now);
      if (cost > 0 && live + cost > CREDIT_LIMIT) v.allowed = 1'b0;
      if (kind == KIND_REFRESH) begin
         if (now < refresh_ready_at || !has_second) v.allowed = 1'b0;
         else if ((coverage & pair) != '0) v.allowed = 1'b0;
      end
      if (op == OP_RECORD) begin
         for (i = 0; i < CREDIT_LIMIT; i++)
            if (stamp_valid[i] && !is_live(i, now)) stamp_valid[i] = 1'b0;
         for (k = 0; k < cost; k++) begin
            stored = 1'b0;
            for (i = 0; i < CREDIT_LIMIT; i++) begin
               if (!stored && !stamp_valid[i]) begin
                  stamp_valid[i] = 1'b1;
                  stamp[i] = now;
                  stored = 1'b1;
               end
            end
            if (!stored) v.overflow = 1'b1;
         end
         if (kind == KIND_REFRESH && has_second) begin
            if ((coverage & pair) != '0) begin
               v.repeat_err = 1'b1;
            end else begin
               coverage = coverage | pair;
               if (coverage == ROUND_FULL) begin
                  coverage = '0;
                  v.round_done = 1'b1;
                  next_at = {1'b0, now} + 33'(gap_long);
               end else begin
                  next_at = {1'b0, now} + 33'(gap_short);
               end
               refresh_ready_at = next_at[32] ? '1 : next_at[31:0];
            end
         end
         live = live_at(now);
      end
      v.live = (live > 7) ? 3'd7 : 3'(live);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         faw_window = 16'd32;
         gap_short = 16'd8;
         gap_long = 16'd16;
         stamp_valid = '0;
         coverage = '0;
         refresh_ready_at = '0;
         pending_verdicts.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               ADDR_FAW_WINDOW: faw_window = csr_pwdata[15:0];
               ADDR_GAP_SHORT:  gap_short = csr_pwdata[15:0];
               ADDR_GAP_LONG:   gap_long = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            judge_command(req_tuser[0], req_tuser[2:1], req_tdata[31:0],
                          {req_tdata[33:32], req_tdata[35:34]}, req_tdata[36],
                          {req_tdata[38:37], req_tdata[40:39]}, want);
            pending_verdicts = {pending_verdicts, want};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{allowed: rsp_tdata[0], repeat_err: rsp_tdata[1],
                    round_done: rsp_tdata[2], overflow: rsp_tdata[3],
                    live: rsp_tdata[6:4]};
            if (pending_verdicts.size() == 0) begin
               if (mismatches < 10)
                  $display({"unexpected result item: ",
                            "allowed=%0d repeat=%0d done=%0d ovf=%0d live=%0d"},
                           got.allowed, got.repeat_err, got.round_done,
                           got.overflow, got.live);
               mismatches++;
            end else begin
               want = pending_verdicts[0];
               pending_verdicts.delete(0);
               if (got.allowed != want.allowed || got.repeat_err != want.repeat_err ||
                   got.round_done != want.round_done || got.overflow != want.overflow ||
                   got.live != want.live) begin
                  if (mismatches < 10)
                     $display({"result mismatch: expected allowed=%0d repeat=%0d ",
                               "done=%0d ovf=%0d live=%0d, got allowed=%0d ",
                               "repeat=%0d done=%0d ovf=%0d live=%0d"},
                              want.allowed, want.repeat_err, want.round_done,
                              want.overflow, want.live, got.allowed,
                              got.repeat_err, got.round_done, got.overflow,
                              got.live);
                  mismatches++;
               end
            end
         end
      end
      mismatch_count <= mismatches;
      open_count <= pending_verdicts.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_faw_and_refresh_pair_checker_core.sv =====
// ----------------------------------------------------------------------------
// tb_faw_and_refresh_pair_checker_core: stimulus and verdict for the checker core
// runs a directed sweep over credit, expiry and refresh round cases, then
// random phases under several register settings with random idling on both
// channels; a separate checker predicts and compares every result item
// ----------------------------------------------------------------------------
`default_nettype none

module tb_faw_and_refresh_pair_checker_core;
   import frpc_pkg::*;

   // register byte addresses, one 32-bit word per register
   localparam logic [3:0] ADDR_FAW_WINDOW = 4'h0;
   localparam logic [3:0] ADDR_GAP_SHORT  = 4'h4;
   localparam logic [3:0] ADDR_GAP_LONG   = 4'h8;

   // command kind with no meaning of its own, handled as another command
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // cycles with no handshake at all before the run is declared hung
   localparam int IDLE_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [0] op, [2:1] command_kind
   logic [2:0]  req_tuser = '0;
   // [31:0] cycle, [33:32] first_bank_group, [35:34] first_bank,
   // [36] second_present, [38:37] second_bank_group, [40:39] second_bank
   logic [47:0] req_tdata = '0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] allowed, [1] repeat_error, [2] round_done, [3] credit_overflow,
   // [6:4] live credit count
   logic [7:0]  rsp_tdata;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatch_count;
   int          open_count;

   // stimulus bookkeeping
   logic [31:0] now_cycle = '0;
   int          span = 32;
   logic [15:0] gap_long_now = 16'd16;
   logic [15:0] cov_mirror = '0;
   int          items_sent = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          idle_cycles = 0;

   always #6 clock = ~clock;

   faw_and_refresh_pair_checker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frpc_result_checker #(
      .ADDR_FAW_WINDOW (ADDR_FAW_WINDOW),
      .ADDR_GAP_SHORT  (ADDR_GAP_SHORT),
      .ADDR_GAP_LONG   (ADDR_GAP_LONG)
   ) verdict_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   // cycle moved forward by step, clamped at the top of the 32-bit range
   function automatic logic [31:0] later(input int step);
      logic [32:0] sum;
      sum = {1'b0, now_cycle} + 33'(step);
      return sum[32] ? '1 : sum[31:0];
   endfunction

   // random forward drift: often none, sometimes a few cycles, sometimes
   // several windows at once so that credits expire
   function automatic logic [31:0] drift();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return now_cycle;
      if (r < 6) return later($urandom_range(1, 3));
      if (r < 9) return later($urandom_range(1, span));
      return later($urandom_range(span, 4 * span));
   endfunction

   // one request item; valid stays high across back-to-back items and is
   // only dropped when a gap is drawn
   task automatic issue_cmd(input logic op, input logic [1:0] kind, input logic [31:0] at_cycle,
                            input logic [3:0] first_idx, input logic has_second,
                            input logic [3:0] second_idx);
      int          gap;
      logic [15:0] pair;
      if ($urandom_range(0, 39) == 0) req_calm = ~req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 19);
      now_cycle = at_cycle;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {kind, op};
      req_tdata <= {7'd0, second_idx[1:0], second_idx[3:2], has_second,
                    first_idx[1:0], first_idx[3:2], at_cycle};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      // keep track of the round so that well-formed pairs pick fresh banks
      pair = (16'd1 << first_idx) | (16'd1 << second_idx);
      if (op == OP_RECORD && kind == KIND_REFRESH && has_second && (cov_mirror & pair) == '0) begin
         cov_mirror = cov_mirror | pair;
         if (cov_mirror == ROUND_FULL) cov_mirror = '0;
      end
   endtask

   // sender holds off until every result item is back and the pipe is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] window, input logic [15:0] short_gap,
                             input logic [15:0] long_gap);
      logic [3:0]  addr [3];
      logic [15:0] value [3];
      int          i;
      drain();
      addr[0] = ADDR_FAW_WINDOW;
      addr[1] = ADDR_GAP_SHORT;
      addr[2] = ADDR_GAP_LONG;
      value[0] = window;
      value[1] = short_gap;
      value[2] = long_gap;
      // back-to-back writes keep psel high and return to setup each time
      for (i = 0; i < 3; i++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= addr[i];
         csr_pwdata <= {16'd0, value[i]};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // cycle steps scale with the slowest timing in force
      span = window;
      if (short_gap > span) span = short_gap;
      if (long_gap > span) span = long_gap;
      if (span < 4) span = 4;
      gap_long_now = long_gap;
   endtask

   // refresh of one or two banks not yet covered this round, mostly far enough
   // past the previous one to clear the gap
   task automatic refresh_pair();
      logic [3:0]  a;
      logic [3:0]  b;
      logic [31:0] at;
      a = 4'($urandom_range(0, 15));
      while (cov_mirror[a]) a = a + 4'd1;
      b = 4'($urandom_range(0, 15));
      if ($countones(~cov_mirror) == 1 || $urandom_range(0, 9) == 0) begin
         b = a;
      end else begin
         while (cov_mirror[b] || b == a) b = b + 4'd1;
      end
      at = ($urandom_range(0, 4) < 3) ? later(gap_long_now + $urandom_range(0, 3)) : drift();
      if ($urandom_range(0, 2) == 0) issue_cmd(OP_CHECK, KIND_REFRESH, at, a, 1'b1, b);
      issue_cmd(OP_RECORD, KIND_REFRESH, at, a, 1'b1, b);
   endtask

   // random traffic: mostly refresh rounds and act2 bursts, some other
   // commands, and a share of fully random noise
   task automatic random_phase(input int count);
      int          first;
      int          r;
      logic        op;
      logic [1:0]  kind;
      logic [31:0] at;
      first = items_sent;
      while (items_sent - first < count) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            refresh_pair();
         end else if (r < 70) begin
            at = drift();
            op = ($urandom_range(0, 4) == 0) ? OP_CHECK : OP_RECORD;
            if (r < 50) issue_cmd(OP_CHECK, KIND_ACT2, at, 4'($urandom_range(0, 15)), 1'b0, '0);
            issue_cmd(op, KIND_ACT2, at, 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         end else if (r < 78) begin
            kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_UNUSED;
            op = $urandom_range(0, 1) ? OP_RECORD : OP_CHECK;
            issue_cmd(op, kind, drift(), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         end else begin
            op = $urandom_range(0, 1) ? OP_RECORD : OP_CHECK;
            issue_cmd(op, 2'($urandom_range(0, 3)), drift(), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         end
      end
   endtask

   // result side: random stall per item, with calm stretches of none
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_calm = ~rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // watchdog: any handshake on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed sweep at the reset timing: window 32, short gap 8, long gap 16
      write_regs(16'd32, 16'd8, 16'd16);
      issue_cmd(OP_CHECK, KIND_ACT2, 32'd0, 4'd0, 1'b0, 4'd0);
      issue_cmd(OP_RECORD, KIND_ACT2, 32'd0, 4'd0, 1'b0, 4'd0);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd0, 4'd0, 1'b1, 4'd1);
      issue_cmd(OP_RECORD, KIND_ACT2, 32'd1, 4'd2, 1'b0, 4'd0);
      // window full: check refused, record drops the credit as overflow
      issue_cmd(OP_CHECK, KIND_ACT2, 32'd2, 4'd2, 1'b0, 4'd0);
      issue_cmd(OP_RECORD, KIND_ACT2, 32'd2, 4'd2, 1'b0, 4'd0);
      // refresh with no secondary bank: credits only, coverage untouched
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd3, 4'd5, 1'b0, 4'd0);
      issue_cmd(OP_CHECK, KIND_REFRESH, 32'd4, 4'd2, 1'b1, 4'd3);
      // all credits expired; a pair reusing a covered bank is refused and flagged
      issue_cmd(OP_CHECK, KIND_REFRESH, 32'd40, 4'd0, 1'b1, 4'd4);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd40, 4'd0, 1'b1, 4'd4);
      issue_cmd(OP_RECORD, KIND_UNUSED, 32'd40, 4'd15, 1'b1, 4'd15);
      issue_cmd(OP_RECORD, KIND_OTHER, 32'd41, 4'd7, 1'b1, 4'd8);
      // same bank twice covers a single bank
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd80, 4'd15, 1'b1, 4'd15);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd120, 4'd2, 1'b1, 4'd3);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd160, 4'd4, 1'b1, 4'd5);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd200, 4'd6, 1'b1, 4'd7);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd240, 4'd8, 1'b1, 4'd9);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd280, 4'd10, 1'b1, 4'd11);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd320, 4'd12, 1'b1, 4'd13);
      // last bank closes the round, then the long gap holds
      issue_cmd(OP_CHECK, KIND_REFRESH, 32'd400, 4'd14, 1'b1, 4'd14);
      issue_cmd(OP_RECORD, KIND_REFRESH, 32'd400, 4'd14, 1'b1, 4'd14);
      issue_cmd(OP_CHECK, KIND_REFRESH, 32'd410, 4'd0, 1'b1, 4'd1);
      issue_cmd(OP_CHECK, KIND_REFRESH, 32'd416, 4'd0, 1'b1, 4'd1);
      // credits stamped at 400 leave the window exactly at 432
      issue_cmd(OP_CHECK, KIND_ACT2, 32'd432, 4'd0, 1'b0, 4'd0);

      random_phase(190);

      // zero timing, with a full drain halfway through
      write_regs(16'd0, 16'd0, 16'd0);
      random_phase(95);
      drain();
      random_phase(95);

      write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
      random_phase(190);

      write_regs(16'd1, 16'd1, 16'd1);
      random_phase(190);

      write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(190);

      write_regs(16'($urandom_range(2, 64)), 16'($urandom_range(0, 64)),
                 16'($urandom_range(0, 64)));
      random_phase(190);

      // top of the cycle range: refresh deadlines saturate, credits never age out
      write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      if (now_cycle < 32'hFFFF_FF00) now_cycle = 32'hFFFF_FF00;
      span = 16;
      random_phase(100);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && open_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
